>>> hdl/kht_pkg.sv
// Package for the keyword hash table: field widths, result codes, action codes,
// controller states and the control bundle toward the table storage.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package kht_pkg;

  localparam int CHAR_W   = 7;
  localparam int ID_W     = 10;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_IDENT     = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_COLLISION = 3'd3,
    ST_TOO_LONG  = 3'd4
  } kht_status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } kht_action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_COPY,
    S_CMP,
    S_EMIT
  } kht_state_t;

  // Strobes from the controller to the table storage.
  typedef struct packed {
    logic meta_rd;
    logic meta_wr;
    logic char_rd;
    logic char_wr;
  } kht_tbl_ctl_t;

endpackage

`default_nettype wire

>>> hdl/kht_if.sv
// Channel interfaces of the keyword hash table: character input, result output
// and the configuration write channel. Depends on kht_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kht_in_if import kht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic [ID_W-1:0]   new_token_id;

  modport source (output valid, action, char_code, last_char, new_token_id, input ready);
  modport sink   (input valid, action, char_code, last_char, new_token_id, output ready);
endinterface

interface kht_out_if import kht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     token_id;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, status, token_id, slot_index, input ready);
  modport sink   (input valid, status, token_id, slot_index, output ready);
endinterface

interface kht_cfg_if import kht_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] identifier_id;

  modport source (output valid, identifier_id, input ready);
  modport sink   (input valid, identifier_id, output ready);
endinterface

`default_nettype wire

>>> hdl/kht_hash.sv
// Polynomial hash unit: hash = (HASH_MULT * hash + char) mod TABLE_SLOTS.
// Power-of-two tables keep the low bits of the sum; others reduce by reciprocal
// multiply, registering sum, quotient and remainder in turn. Depends on kht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kht_hash import kht_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  parameter int HASH_MULT   = 31,
  localparam int HW         = $clog2(TABLE_SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              first,
  input  wire logic [CHAR_W-1:0] char_code,
  output logic                   busy,
  output logic [HW-1:0]          hash
);

  // Width of HASH_MULT * (TABLE_SLOTS - 1) + largest character.
  localparam int PW = $clog2(HASH_MULT * (TABLE_SLOTS - 1) + (1 << CHAR_W));

  logic [HW-1:0] hash_r;
  logic [HW-1:0] base;
  logic [PW-1:0] sum;

  assign base = first ? '0 : hash_r;
  assign sum  = PW'(HASH_MULT) * PW'(base) + PW'(char_code);
  assign hash = hash_r;

  if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
    assign busy = 1'b0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hash_r <= '0;
      end else if (start) begin
        hash_r <= sum[HW-1:0];
      end
    end
  end else begin : g_recip
    // Exact quotient of any PW-bit value: q = (x * RECIP) >> K.
    localparam int K            = PW + HW;
    localparam int RW           = PW + 2;
    localparam logic [63:0] RECIP =
      ((64'd1 << K) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);

    logic [1:0]       phase_r;
    logic [PW-1:0]    prod_r;
    logic [PW-1:0]    q_r;
    logic [2*PW+1:0]  qprod;
    logic [PW-1:0]    rem;

    assign qprod = {{(PW + 2){1'b0}}, prod_r} * {{PW{1'b0}}, RECIP[RW-1:0]};
    assign rem   = prod_r - PW'(q_r * PW'(TABLE_SLOTS));
    assign busy  = (phase_r != 2'd0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r <= 2'd0;
        hash_r  <= '0;
      end else begin
        unique case (phase_r)
          2'd0: begin
            if (start) begin
              prod_r  <= sum;
              phase_r <= 2'd1;
            end
          end
          2'd1: begin
            q_r     <= PW'(qprod >> K);
            phase_r <= 2'd2;
          end
          default: begin
            hash_r  <= rem[HW-1:0];
            phase_r <= 2'd0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/kht_table.sv
// Keyword table storage: per-slot metadata (valid, length, id) and the stored
// characters, both memories with registered reads, plus the clearing pass that
// invalidates every slot after reset. Depends on kht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kht_table import kht_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  parameter int MAX_LEN     = 16,
  localparam int HW         = $clog2(TABLE_SLOTS),
  localparam int LW         = $clog2(MAX_LEN + 1),
  localparam int CAW        = $clog2(TABLE_SLOTS * MAX_LEN)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kht_tbl_ctl_t      ctl,
  input  wire logic [HW-1:0]     meta_addr,
  input  wire logic [LW-1:0]     meta_wr_len,
  input  wire logic [ID_W-1:0]   meta_wr_id,
  input  wire logic [CAW-1:0]    char_wr_addr,
  input  wire logic [CHAR_W-1:0] char_wr_data,
  input  wire logic [CAW-1:0]    char_rd_addr,
  output logic                   clr_busy,
  output logic                   meta_vld,
  output logic [LW-1:0]          meta_len,
  output logic [ID_W-1:0]        meta_id,
  output logic [CHAR_W-1:0]      char_q
);

  typedef struct packed {
    logic            vld;
    logic [LW-1:0]   len;
    logic [ID_W-1:0] id;
  } kht_meta_t;

  kht_meta_t         meta_mem [TABLE_SLOTS];
  kht_meta_t         meta_q;
  logic [CHAR_W-1:0] char_mem [TABLE_SLOTS * MAX_LEN];

  logic          clr_busy_r;
  logic [HW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == HW'(TABLE_SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      meta_mem[clr_cnt_r] <= '0;
    end else if (ctl.meta_wr) begin
      meta_mem[meta_addr] <= '{vld: 1'b1, len: meta_wr_len, id: meta_wr_id};
    end
    if (ctl.meta_rd) begin
      meta_q <= meta_mem[meta_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.char_wr) begin
      char_mem[char_wr_addr] <= char_wr_data;
    end
    if (ctl.char_rd) begin
      char_q <= char_mem[char_rd_addr];
    end
  end

  assign clr_busy = clr_busy_r;
  assign meta_vld = meta_q.vld;
  assign meta_len = meta_q.len;
  assign meta_id  = meta_q.id;

endmodule

`default_nettype wire

>>> hdl/keyword_hash_table_top.sv
// Keyword hash table for a lexer. Words come in one character per beat on the
// input channel, the final character marked by last_char; only the action and
// new_token_id of that final beat count. Each character goes through a
// polynomial hash; the block takes one beat per cycle while idle when
// TABLE_SLOTS is a power of two, and otherwise takes the next beat only once
// the hash unit has reduced the last one modulo the table size by a reciprocal
// multiply. The final beat of a word yields one result beat: an insert stores
// the word in its hash slot or reports a collision, a search returns the
// stored id when the slot holds exactly this word and the configured
// identifier id otherwise, and a word longer than MAX_LEN gives the too-long
// status without touching the table. A too-long word skips the table lookup; a
// collision, or a search that the slot's valid bit or stored length already
// rules out, ends at the lookup; a completed insert or a full compare then
// handles one stored character per cycle, and a compare stops once the read of
// the first differing character returns. Any wait for the output register to
// free up lengthens this work. Results sit in an output register, so a new
// word can stream in while the last result waits. After reset the block
// invalidates every slot before it takes its first input beat; configuration
// writes are taken at any time and should only be issued while the block is
// idle.
`timescale 1ns / 1ps
`default_nettype none

module keyword_hash_table_top import kht_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  parameter int MAX_LEN     = 16,
  parameter int HASH_MULT   = 31
) (
  input  wire logic clk,
  input  wire logic rst_n,
  kht_in_if.sink    in_chan,
  kht_out_if.source out_chan,
  kht_cfg_if.sink   cfg_chan
);

  localparam int HW  = $clog2(TABLE_SLOTS);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int IW  = $clog2(MAX_LEN);
  localparam int CAW = $clog2(TABLE_SLOTS * MAX_LEN);

  kht_state_t state_r, state_nxt;

  // Word being collected.
  logic [LW-1:0]     len_r;
  logic              too_long_r;
  logic              room;
  logic [CHAR_W-1:0] wb_mem [MAX_LEN];
  logic [CHAR_W-1:0] wb_q;

  // Closed word under processing.
  logic [LW-1:0]     wlen_r;
  logic              wtl_r;
  kht_action_t       act_r;
  logic [ID_W-1:0]   new_id_r;
  logic [CAW-1:0]    base_r;
  logic [LW-1:0]     idx_r;
  logic              pend_vld_r;
  logic [CAW-1:0]    cp_addr_r;
  logic [CAW-1:0]    char_addr;

  // Pending result and the output register.
  kht_status_t       res_status_r;
  logic [ID_W-1:0]   res_token_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              out_valid_r;
  kht_status_t       out_status_r;
  logic [ID_W-1:0]   out_token_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [ID_W-1:0]   identifier_id_r;

  // Hash unit and table storage.
  logic                hash_busy;
  logic [HW-1:0]       hash;
  logic [HW+SLOT_W-1:0] hash_wide;
  kht_tbl_ctl_t        tbl_ctl;
  logic                clr_busy;
  logic                meta_vld;
  logic [LW-1:0]       meta_len;
  logic [ID_W-1:0]     meta_id;
  logic [CHAR_W-1:0]   char_q;

  // Controller outputs.
  logic in_ready;
  logic in_acc;
  logic issue;
  logic out_load;
  logic mismatch;

  assign in_acc    = in_chan.valid && in_ready;
  assign room      = (len_r < LW'(MAX_LEN));
  assign char_addr = base_r + CAW'(idx_r);
  assign mismatch  = pend_vld_r && (wb_q != char_q);
  assign hash_wide = {{SLOT_W{1'b0}}, hash};

  kht_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .HASH_MULT   (HASH_MULT)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .first     (len_r == '0),
    .char_code (in_chan.char_code),
    .busy      (hash_busy),
    .hash      (hash)
  );

  kht_table #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_LEN     (MAX_LEN)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (tbl_ctl),
    .meta_addr    (hash),
    .meta_wr_len  (wlen_r),
    .meta_wr_id   (new_id_r),
    .char_wr_addr (cp_addr_r),
    .char_wr_data (wb_q),
    .char_rd_addr (char_addr),
    .clr_busy     (clr_busy),
    .meta_vld     (meta_vld),
    .meta_len     (meta_len),
    .meta_id      (meta_id),
    .char_q       (char_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_chan.last_char) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (!hash_busy) begin
          state_nxt = wtl_r ? S_EMIT : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (act_r == ACT_INSERT) begin
          state_nxt = meta_vld ? S_EMIT : S_COPY;
        end else begin
          state_nxt = (!meta_vld || meta_len != wlen_r) ? S_EMIT : S_CMP;
        end
      end
      S_COPY: begin
        if (pend_vld_r && idx_r == wlen_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_CMP: begin
        if (mismatch || idx_r == wlen_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready        = (state_r == S_IDLE) && !hash_busy;
    issue           = (state_r == S_COPY || state_r == S_CMP) && (idx_r < wlen_r);
    tbl_ctl.meta_rd = (state_r == S_HASH) && !hash_busy && !wtl_r;
    tbl_ctl.meta_wr = (state_r == S_COPY) && pend_vld_r && (idx_r == wlen_r);
    tbl_ctl.char_rd = (state_r == S_CMP) && issue;
    tbl_ctl.char_wr = (state_r == S_COPY) && pend_vld_r;
    out_load        = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);
  end

  // Word buffer memory: written as characters arrive, read while copying or
  // comparing the closed word.
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      wb_mem[len_r[IW-1:0]] <= in_chan.char_code;
    end
    if (issue) begin
      wb_q <= wb_mem[idx_r[IW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      len_r           <= '0;
      too_long_r      <= 1'b0;
      pend_vld_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      identifier_id_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_chan.valid) begin
        identifier_id_r <= cfg_chan.identifier_id;
      end

      // The final character closes the word and clears the collector.
      if (in_acc) begin
        if (in_chan.last_char) begin
          len_r      <= '0;
          too_long_r <= 1'b0;
        end else if (room) begin
          len_r <= len_r + 1'b1;
        end else begin
          too_long_r <= 1'b1;
        end
      end

      pend_vld_r <= issue;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath of the closed word and the result.
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.last_char) begin
      wlen_r   <= room ? len_r + 1'b1 : len_r;
      wtl_r    <= too_long_r || !room;
      act_r    <= kht_action_t'(in_chan.action);
      new_id_r <= in_chan.new_token_id;
    end

    if (issue) begin
      idx_r     <= idx_r + 1'b1;
      cp_addr_r <= char_addr;
    end

    unique case (state_r)
      S_HASH: begin
        if (!hash_busy) begin
          res_slot_r   <= hash_wide[SLOT_W-1:0];
          base_r       <= CAW'(hash) * CAW'(MAX_LEN);
          res_status_r <= ST_TOO_LONG;
          res_token_r  <= '0;
        end
      end
      S_LOOKUP: begin
        idx_r <= '0;
        if (act_r == ACT_INSERT) begin
          res_status_r <= meta_vld ? ST_COLLISION : ST_INSERTED;
          res_token_r  <= '0;
        end else if (!meta_vld || meta_len != wlen_r) begin
          res_status_r <= ST_IDENT;
          res_token_r  <= identifier_id_r;
        end else begin
          // Presumed found; a character mismatch overrides it below.
          res_status_r <= ST_FOUND;
          res_token_r  <= meta_id;
        end
      end
      S_CMP: begin
        if (mismatch) begin
          res_status_r <= ST_IDENT;
          res_token_r  <= identifier_id_r;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_status_r <= res_status_r;
      out_token_r  <= res_token_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign in_chan.ready       = in_ready;
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.token_id   = out_token_r;
  assign out_chan.slot_index = out_slot_r;

endmodule

`default_nettype wire
